### rtl/ascgm_pkg.sv
package ascgm_pkg;

	// Field and datapath widths
	localparam int TIME_W     = 32;
	localparam int COUNT_W    = 16;
	localparam int GAP_W      = 16;
	localparam int SPEED_W    = 16;
	localparam int GUST_W     = 14;
	localparam int CODE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int SCALE_W    = 15;
	localparam int NUM_W      = SCALE_W + COUNT_W;
	localparam int DEN_W      = 24;
	localparam int STEP_W     = 5;
	localparam int OUT_W      = 48;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd3;

	// Register reset values
	localparam logic [DEN_W-1:0] INTERVAL_RST = 24'd4000;
	localparam logic [7:0]       DEBOUNCE_RST = 8'd3;

	// Scale times eight for each sensor kind
	localparam logic [SCALE_W-1:0] SCALE8_KIND0 = 15'd19200;
	localparam logic [SCALE_W-1:0] SCALE8_KIND1 = 15'd28800;

	localparam logic [GAP_W-1:0]   NO_GAP      = 16'hFFFF;
	localparam logic [GUST_W-1:0]  GUST_MAX    = 14'd9600;
	localparam logic [SPEED_W-1:0] SPEED_MAX   = 16'hFFFF;
	localparam logic [STEP_W-1:0]  SPEED_STEPS = STEP_W'(NUM_W);
	localparam logic [STEP_W-1:0]  GUST_STEPS  = STEP_W'(SCALE_W);

	// Action codes
	localparam logic ACT_PULSE  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// Divider request and status
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Piecewise compression of a speed value into one byte
	function automatic logic [CODE_W-1:0] compress(input logic [SPEED_W-1:0] v);
		logic [SPEED_W-1:0] r;
		if (v <= 16'd400) begin
			r = v >> 2;
		end else if (v < 16'd1000) begin
			r = (v >> 3) + 16'd50;
		end else if (v < 16'd2280) begin
			r = (v >> 4) + 16'd113;
		end else begin
			r = 16'd255;
		end
		return r[CODE_W-1:0];
	endfunction

endpackage

### rtl/ascgm_div.sv
module ascgm_div
	import ascgm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	// Shift in the next numerator bit and try the subtraction
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end
		end
	end

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end else if (req.start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

`ifndef NO_ASSERTIONS
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with no steps left");
`endif

endmodule

### rtl/anemometer_speed_gust_meter_core.sv
// Pulse beat: state updated at the edge after acceptance; ready again once back in idle.
// Report beat: after acceptance the sequencer passes through the multiply state, the divider
// start and the shared serial divider (31 steps for mean speed, then 15 for gust, which is
// skipped when no gap was seen); ready again in the cycle the result appears.
// One beat is in work at a time; a result still held for the sink stalls only the last step.
// Reset is asynchronous, active low: registers at defaults, count 0, no gap seen.
module anemometer_speed_gust_meter_core
	import ascgm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TIME_W-1:0]     s_tdata,  // time_ms[31:0]
	input  logic                  s_tuser,  // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // speed_x8, gust_x8, speed_code, gust_code, pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PULSE = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SPD   = 3'd3;
	localparam logic [2:0] ST_WAITS = 3'd4;
	localparam logic [2:0] ST_WAITG = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]         state_q;
	logic [DEN_W-1:0]   interval_q;
	logic               kind_q;
	logic               sleep_q;
	logic [7:0]         debounce_q;
	logic [TIME_W-1:0]  last_q;
	logic               seen_q;
	logic [COUNT_W-1:0] count_q;
	logic [GAP_W-1:0]   gap_min_q;
	logic [TIME_W-1:0]  time_q;
	logic [NUM_W-1:0]   prod_q;
	logic [SPEED_W-1:0] speed_q;
	logic [GUST_W-1:0]  gust_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_q;

	logic [SCALE_W-1:0] scale8;
	logic [TIME_W-1:0]  gap;
	logic               out_free;
	div_req_t           div_req;
	div_stat_t          div_stat;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [NUM_W-1:0]   div_quo;

	assign scale8   = kind_q ? SCALE8_KIND1 : SCALE8_KIND0;
	assign gap      = time_q - last_q;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			kind_q     <= 1'b0;
			sleep_q    <= 1'b0;
			debounce_q <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_KIND:     kind_q     <= cfg_data[0];
				CFG_SLEEP:    sleep_q    <= cfg_data[0];
				CFG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Drive the shared divider: mean speed first, then gust
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = SPEED_STEPS;
		div_num       = prod_q;
		div_den       = (interval_q == '0) ? DEN_W'(1) : interval_q;
		if (state_q == ST_SPD) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_WAITS && div_stat.done && gap_min_q != NO_GAP) begin
			div_req.start = 1'b1;
			div_req.steps = GUST_STEPS;
			div_num       = {scale8, {COUNT_W{1'b0}}};
			div_den       = (gap_min_q == '0) ? DEN_W'(1) : {8'd0, gap_min_q};
		end
	end

	ascgm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// Sequencer and meter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= '0;
			seen_q    <= 1'b0;
			count_q   <= '0;
			gap_min_q <= NO_GAP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (s_tuser == ACT_REPORT) ? ST_MUL : ST_PULSE;
					end
				end
				ST_PULSE: begin
					// drop the pulse in deep sleep or inside the debounce window
					if (!sleep_q && gap >= {24'd0, debounce_q}) begin
						last_q <= time_q;
						if (seen_q && gap < {16'd0, gap_min_q}) begin
							gap_min_q <= gap[GAP_W-1:0];
						end
						seen_q  <= 1'b1;
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_MUL: state_q <= ST_SPD;
				ST_SPD: state_q <= ST_WAITS;
				ST_WAITS: begin
					if (div_stat.done) begin
						state_q <= (gap_min_q == NO_GAP) ? ST_FIN : ST_WAITG;
					end
				end
				ST_WAITG: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						count_q   <= '0;
						gap_min_q <= NO_GAP;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_q <= s_tdata;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {{COUNT_W{1'b0}}, scale8} * {{SCALE_W{1'b0}}, count_q};
		end
		if (state_q == ST_WAITS && div_stat.done) begin
			speed_q <= (|div_quo[NUM_W-1:SPEED_W]) ? SPEED_MAX : div_quo[SPEED_W-1:0];
			gust_q  <= '0;
		end
		if (state_q == ST_WAITG && div_stat.done) begin
			gust_q <= (div_quo[SCALE_W-1:0] > {1'b0, GUST_MAX}) ?
				GUST_MAX : div_quo[GUST_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			out_q <= {2'b00, compress({2'b00, gust_q}), compress(speed_q), gust_q, speed_q};
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef NO_ASSERTIONS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_PULSE) |-> !div_stat.busy && !div_stat.done)
		else $error("divider active outside a report");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> m_tvalid && count_q == '0 && gap_min_q == NO_GAP)
		else $error("report did not load result and clear meter");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");
`endif

endmodule
